// File: rtl/ord_pkg.sv
// Shared types and constants for the overwriting ring deque.
`default_nettype none

package ord_pkg;

    localparam int CNT_W   = 7;
    localparam int REQ_W   = 3;
    localparam int IDX_W   = 6;
    localparam int VALUE_W = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_PEEK       = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_POP_BACK   = 3'd4
    } t_req;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [CNT_W-1:0] fill_count;
    } t_resp;

endpackage

`default_nettype wire

// File: rtl/overwriting_ring_deque.sv
// Top level of the overwriting ring deque: request register, control and slot RAM.
`default_nettype none

// A request is taken at every clock edge where start is high; busy never rises, so one
// request enters per cycle. Its result appears on the result ports with o_result_strobe
// high for one cycle, after the request and response registers; results come out in
// request order. The receiver cannot stall, so every strobed transaction must be taken
// when shown. The rate is set by the slot RAM, which serves one push write or one peek
// or pop read per cycle, and by the same-cycle head and count update. Writing the
// capacity empties the ring; the user must write it only while idle (not enforced).
module overwriting_ring_deque import ord_pkg::*; #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [REQ_W-1:0]     i_req_type,
    input  wire logic [VALUE_W-1:0]   i_entry_value,
    input  wire logic [IDX_W-1:0]     i_peek_index,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CNT_W-1:0]     i_cfg_data,
    output logic                      o_result_strobe,
    output logic      [VALUE_W-1:0]   o_read_value,
    output logic                      o_hit,
    output logic      [CNT_W-1:0]     o_fill_count
);

    localparam int AW = $clog2(DEPTH);

    logic                 r_in_valid;
    logic [REQ_W-1:0]     r_req_type;
    logic [WORD_BITS-1:0] r_entry_value;
    logic [IDX_W-1:0]     r_peek_index;

    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    t_resp                resp;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req_type    <= i_req_type;
            r_entry_value <= i_entry_value[WORD_BITS-1:0];
            r_peek_index  <= i_peek_index;
        end
    end

    ord_ctl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (r_in_valid),
        .i_req_type    (r_req_type),
        .i_entry_value (r_entry_value),
        .i_peek_index  (r_peek_index),
        .o_ram_we      (ram_we),
        .o_ram_re      (ram_re),
        .o_ram_addr    (ram_addr),
        .o_ram_wdata   (ram_wdata),
        .o_resp        (resp)
    );

    ord_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    assign o_result_strobe = resp.valid;
    assign o_hit           = resp.hit;
    assign o_fill_count    = resp.fill_count;
    assign o_read_value    = resp.hit ? VALUE_W'(ram_rdata) : '0;

endmodule

`default_nettype wire

// File: rtl/ord_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module ord_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/ord_ctl.sv
// Head, count and capacity registers with slot address generation for the ring deque.
`default_nettype none

module ord_ctl import ord_pkg::*; #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    input  wire logic [CNT_W-1:0]         i_cfg_data,
    input  wire logic                     i_req_valid,
    input  wire logic [REQ_W-1:0]         i_req_type,
    input  wire logic [WORD_BITS-1:0]     i_entry_value,
    input  wire logic [IDX_W-1:0]         i_peek_index,
    output logic                          o_ram_we,
    output logic                          o_ram_re,
    output logic      [$clog2(DEPTH)-1:0] o_ram_addr,
    output logic      [WORD_BITS-1:0]     o_ram_wdata,
    output t_resp                         o_resp
);

    localparam int AW      = $clog2(DEPTH);
    localparam int SW      = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int CAP_MAX = (DEPTH < 127) ? DEPTH : 127;
    localparam int CAP_RST = (DEPTH < 64) ? DEPTH : 64;

    logic [AW-1:0]    r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_cap, n_cap;
    t_resp            r_resp, n_resp;

    logic [CNT_W-1:0] pos;
    logic [AW-1:0]    slot_pos;
    logic [AW-1:0]    slot_next;
    logic [AW-1:0]    head_dec;
    logic             not_full;
    logic             not_empty;

    function automatic logic [AW-1:0] slot_of(
        input logic [AW-1:0]    head,
        input logic [CNT_W-1:0] offset,
        input logic [CNT_W-1:0] cap
    );
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(offset);
        if (sum >= SW'(cap)) begin
            sum = sum - SW'(cap);
        end
        return sum[AW-1:0];
    endfunction

    assign not_full  = (r_count < r_cap);
    assign not_empty = (r_count != '0);
    assign head_dec  = (r_head == '0) ? AW'(r_cap - CNT_W'(1)) : (r_head - AW'(1));
    assign slot_next = slot_of(r_head, CNT_W'(1), r_cap);
    assign slot_pos  = slot_of(r_head, pos, r_cap);

    always_comb begin
        case (t_req'(i_req_type))
            REQ_PUSH_BACK: pos = r_count;
            REQ_PEEK:      pos = CNT_W'(i_peek_index);
            REQ_POP_BACK:  pos = r_count - CNT_W'(1);
            default:       pos = '0;
        endcase
    end

    always_comb begin
        n_head          = r_head;
        n_count         = r_count;
        n_cap           = r_cap;
        n_resp.valid    = i_req_valid;
        n_resp.hit      = 1'b0;
        o_ram_we        = 1'b0;
        o_ram_re        = 1'b0;
        o_ram_addr      = slot_pos;
        o_ram_wdata     = i_entry_value;

        if (i_req_valid) begin
            case (t_req'(i_req_type))
                REQ_PUSH_FRONT: begin
                    n_head     = head_dec;
                    o_ram_addr = head_dec;
                    o_ram_we   = 1'b1;
                    if (not_full) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                REQ_PUSH_BACK: begin
                    o_ram_we = 1'b1;
                    if (not_full) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_head = slot_next;
                    end
                end
                REQ_PEEK: begin
                    if (CNT_W'(i_peek_index) < r_count) begin
                        o_ram_re   = 1'b1;
                        n_resp.hit = 1'b1;
                    end
                end
                REQ_POP_FRONT: begin
                    if (not_empty) begin
                        o_ram_re   = 1'b1;
                        n_resp.hit = 1'b1;
                        n_head     = slot_next;
                        n_count    = r_count - CNT_W'(1);
                    end
                end
                REQ_POP_BACK: begin
                    if (not_empty) begin
                        o_ram_re   = 1'b1;
                        n_resp.hit = 1'b1;
                        n_count    = r_count - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end

        n_resp.fill_count = n_count;

        if (i_cfg_valid) begin
            n_head  = '0;
            n_count = '0;
            if (i_cfg_data == '0) begin
                n_cap = CNT_W'(1);
            end else if (i_cfg_data > CNT_W'(CAP_MAX)) begin
                n_cap = CNT_W'(CAP_MAX);
            end else begin
                n_cap = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_cap   <= CNT_W'(CAP_RST);
            r_resp  <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_cap   <= n_cap;
            r_resp  <= n_resp;
        end
    end

    assign o_resp = r_resp;

endmodule

`default_nettype wire
